/* rtl/vtn_pkg.sv */
// Shared constants, widths, stage map and register codes for the vertex transform block
package vtn_pkg;

  // Fixed-point formats
  localparam int COEF_FRAC_BITS = 12;
  localparam int DIR_FRAC_BITS  = 14;

  // Field widths
  localparam int POS_W    = 24;
  localparam int DIR_W    = 16;
  localparam int TEX_W    = 16;
  localparam int FLAG_W   = 2;
  localparam int COEF_W   = 16;
  localparam int CFG_W    = 48;
  localparam int CFG_IDX_W = 3;
  localparam int OFF_W    = 32;

  // Dot product datapath
  localparam int VEC_W    = 24;
  localparam int PROD_W   = COEF_W + VEC_W;
  localparam int DSUM_W   = PROD_W + 2;
  localparam int P_W      = DSUM_W - COEF_FRAC_BITS;
  localparam int PO_W     = ((P_W > OFF_W) ? P_W : OFF_W) + 1;

  // Direction datapath
  localparam int W_W      = 33 - COEF_FRAC_BITS;
  localparam int SQ_W     = 2 * W_W - 1;
  localparam int S_W      = 2 * W_W + 1;
  localparam int RAD_SHIFT = 14;
  localparam int ROOT_W   = (S_W + RAD_SHIFT + 1) / 2;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int Q_W      = DIR_FRAC_BITS + 2;
  localparam int NUM_SHIFT = DIR_FRAC_BITS + 7;
  localparam int NUM_W    = W_W + NUM_SHIFT + 1;
  localparam int DV_W     = ((NUM_W > ROOT_W + Q_W) ? NUM_W : ROOT_W + Q_W) + 1;

  // Pipeline stage map
  localparam int ST_PROD  = 0;
  localparam int ST_DOT   = 1;
  localparam int ST_SQR   = 2;
  localparam int ST_SUM   = 3;
  localparam int ST_NUM   = ST_SUM + ROOT_W + 1;
  localparam int ST_OUT   = ST_NUM + Q_W + 1;
  localparam int NST      = ST_OUT + 1;

  typedef logic [NST-1:0] stage_en_t;

  // Saturation bounds
  localparam logic signed [PO_W-1:0] POS_MAX = PO_W'(64'sd8388607);
  localparam logic signed [PO_W-1:0] POS_MIN = PO_W'(-64'sd8388608);

  // Reset matrix is the identity
  localparam logic [CFG_W-1:0] ROW_X_RST = CFG_W'(64'd1) << COEF_FRAC_BITS;
  localparam logic [CFG_W-1:0] ROW_Y_RST = CFG_W'(64'd1) << (COEF_FRAC_BITS + COEF_W);
  localparam logic [CFG_W-1:0] ROW_Z_RST = CFG_W'(64'd1) << (COEF_FRAC_BITS + 2 * COEF_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X = 3'd0,
    REG_ROW_Y = 3'd1,
    REG_ROW_Z = 3'd2,
    REG_OFF_X = 3'd3,
    REG_OFF_Y = 3'd4,
    REG_OFF_Z = 3'd5
  } cfg_reg_t;

endpackage

/* rtl/vtn_in_if.sv */
// Vertex request channel: valid, ready and the input vertex fields
interface vtn_in_if import vtn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic signed [DIR_W-1:0] nrm_x;
  logic signed [DIR_W-1:0] nrm_y;
  logic signed [DIR_W-1:0] nrm_z;
  logic signed [DIR_W-1:0] tan_x;
  logic signed [DIR_W-1:0] tan_y;
  logic signed [DIR_W-1:0] tan_z;
  logic [TEX_W-1:0]        tex_u;
  logic [TEX_W-1:0]        tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
                  tan_x, tan_y, tan_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
                  tan_x, tan_y, tan_z, tex_u, tex_v, output ready);
endinterface

/* rtl/vtn_out_if.sv */
// Result channel: valid, ready and the transformed vertex fields
interface vtn_out_if import vtn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] out_pos_x;
  logic signed [POS_W-1:0] out_pos_y;
  logic signed [POS_W-1:0] out_pos_z;
  logic signed [DIR_W-1:0] out_nrm_x;
  logic signed [DIR_W-1:0] out_nrm_y;
  logic signed [DIR_W-1:0] out_nrm_z;
  logic signed [DIR_W-1:0] out_tan_x;
  logic signed [DIR_W-1:0] out_tan_y;
  logic signed [DIR_W-1:0] out_tan_z;
  logic [TEX_W-1:0]        out_tex_u;
  logic [TEX_W-1:0]        out_tex_v;
  logic [FLAG_W-1:0]       degenerate;

  modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
                  out_nrm_z, out_tan_x, out_tan_y, out_tan_z, out_tex_u, out_tex_v,
                  degenerate, input ready);
  modport sink   (input valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
                  out_nrm_z, out_tan_x, out_tan_y, out_tan_z, out_tex_u, out_tex_v,
                  degenerate, output ready);
endinterface

/* rtl/vtn_dot.sv */
// Two-stage row dot product: registered products, then rounded sum
module vtn_dot import vtn_pkg::*; (
  input  logic                    clk,
  input  logic                    en_prod,
  input  logic                    en_sum,
  input  logic [CFG_W-1:0]        row,
  input  logic signed [VEC_W-1:0] vec_x,
  input  logic signed [VEC_W-1:0] vec_y,
  input  logic signed [VEC_W-1:0] vec_z,
  output logic signed [P_W-1:0]   dot_o
);

  localparam logic signed [DSUM_W-1:0] RND_HALF = DSUM_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));

  logic signed [COEF_W-1:0] c0, c1, c2;
  logic signed [PROD_W-1:0] prod_r [3];
  logic signed [DSUM_W-1:0] sum_nxt;
  logic signed [DSUM_W-1:0] shr_nxt;
  logic signed [P_W-1:0]    dot_r;

  assign c0 = $signed(row[COEF_W-1:0]);
  assign c1 = $signed(row[2*COEF_W-1:COEF_W]);
  assign c2 = $signed(row[3*COEF_W-1:2*COEF_W]);

  // Multiply each coefficient by its element
  always_ff @(posedge clk) begin
    if (en_prod) begin
      prod_r[0] <= c0 * vec_x;
      prod_r[1] <= c1 * vec_y;
      prod_r[2] <= c2 * vec_z;
    end
  end

  // Add, then round half up to the output scale
  assign sum_nxt = DSUM_W'(prod_r[0]) + DSUM_W'(prod_r[1]) + DSUM_W'(prod_r[2]) + RND_HALF;
  assign shr_nxt = sum_nxt >>> COEF_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en_sum) begin
      dot_r <= $signed(shr_nxt[P_W-1:0]);
    end
  end

  assign dot_o = dot_r;

endmodule

/* rtl/vtn_dir_lane.sv */
// Direction lane: matrix multiply, length via pipelined square root, per-axis division
module vtn_dir_lane import vtn_pkg::*; (
  input  logic                    clk,
  input  stage_en_t               en,
  input  logic [CFG_W-1:0]        row_x,
  input  logic [CFG_W-1:0]        row_y,
  input  logic [CFG_W-1:0]        row_z,
  input  logic signed [DIR_W-1:0] d_x,
  input  logic signed [DIR_W-1:0] d_y,
  input  logic signed [DIR_W-1:0] d_z,
  output logic signed [DIR_W-1:0] o_x,
  output logic signed [DIR_W-1:0] o_y,
  output logic signed [DIR_W-1:0] o_z,
  output logic                    zero_o
);

  logic signed [P_W-1:0]    dot [3];
  logic signed [W_W-1:0]    w [3];
  logic signed [2*W_W-1:0]  sq_full [3];
  logic [SQ_W-1:0]          sq_r [3];
  logic signed [W_W-1:0]    w2_r [3];
  logic [S_W-1:0]           s_nxt;

  // Root stages
  logic [RAD_W-1:0]         rad_r  [0:ROOT_W];
  logic [ROOT_W:0]          rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0]        root_r [0:ROOT_W];
  logic signed [W_W-1:0]    wq_r   [0:ROOT_W][3];
  logic                     zq_r   [0:ROOT_W];

  // Division stages
  logic [DV_W-1:0]          num_r  [0:Q_W][3];
  logic [Q_W-1:0]           q_r    [0:Q_W][3];
  logic                     neg_r  [0:Q_W][3];
  logic [ROOT_W-1:0]        dvs_r  [0:Q_W];
  logic                     zd_r   [0:Q_W];

  logic signed [DIR_W-1:0]  out_r [3];
  logic                     zero_r;

  vtn_dot u_dot_x (.clk(clk), .en_prod(en[ST_PROD]), .en_sum(en[ST_DOT]), .row(row_x),
                   .vec_x(VEC_W'(d_x)), .vec_y(VEC_W'(d_y)), .vec_z(VEC_W'(d_z)),
                   .dot_o(dot[0]));
  vtn_dot u_dot_y (.clk(clk), .en_prod(en[ST_PROD]), .en_sum(en[ST_DOT]), .row(row_y),
                   .vec_x(VEC_W'(d_x)), .vec_y(VEC_W'(d_y)), .vec_z(VEC_W'(d_z)),
                   .dot_o(dot[1]));
  vtn_dot u_dot_z (.clk(clk), .en_prod(en[ST_PROD]), .en_sum(en[ST_DOT]), .row(row_z),
                   .vec_x(VEC_W'(d_x)), .vec_y(VEC_W'(d_y)), .vec_z(VEC_W'(d_z)),
                   .dot_o(dot[2]));

  // Square each transformed component
  for (genvar i = 0; i < 3; i++) begin : g_sq
    assign w[i]       = $signed(dot[i][W_W-1:0]);
    assign sq_full[i] = w[i] * w[i];
    always_ff @(posedge clk) begin
      if (en[ST_SQR]) begin
        sq_r[i] <= sq_full[i][SQ_W-1:0];
        w2_r[i] <= w[i];
      end
    end
  end

  // Sum of squares, scaled for the root
  assign s_nxt = S_W'(sq_r[0]) + S_W'(sq_r[1]) + S_W'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      rad_r[0]  <= RAD_W'(s_nxt) << RAD_SHIFT;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      zq_r[0]   <= (s_nxt == '0);
      for (int i = 0; i < 3; i++) begin
        wq_r[0][i] <= w2_r[i];
      end
    end
  end

  // One root bit per stage, restoring
  for (genvar s = 1; s <= ROOT_W; s++) begin : g_root
    logic [ROOT_W+2:0] rem2;
    logic [ROOT_W+2:0] trial;
    logic              ge;
    assign rem2  = {rem_r[s-1], rad_r[s-1][RAD_W-1 -: 2]};
    assign trial = {1'b0, root_r[s-1], 2'b01};
    assign ge    = (rem2 >= trial);
    always_ff @(posedge clk) begin
      if (en[ST_SUM + s]) begin
        rem_r[s]  <= ge ? (ROOT_W+1)'(rem2 - trial) : rem2[ROOT_W:0];
        root_r[s] <= {root_r[s-1][ROOT_W-2:0], ge};
        rad_r[s]  <= rad_r[s-1] << 2;
        zq_r[s]   <= zq_r[s-1];
        for (int i = 0; i < 3; i++) begin
          wq_r[s][i] <= wq_r[s-1][i];
        end
      end
    end
  end

  // Build the numerators: magnitude scaled plus half the divisor
  for (genvar i = 0; i < 3; i++) begin : g_num
    logic [W_W-1:0] mag;
    assign mag = wq_r[ROOT_W][i][W_W-1] ? W_W'(-wq_r[ROOT_W][i]) : W_W'(wq_r[ROOT_W][i]);
    always_ff @(posedge clk) begin
      if (en[ST_NUM]) begin
        num_r[0][i] <= (DV_W'(mag) << NUM_SHIFT) + DV_W'(root_r[ROOT_W] >> 1);
        q_r[0][i]   <= '0;
        neg_r[0][i] <= wq_r[ROOT_W][i][W_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_NUM]) begin
      dvs_r[0] <= root_r[ROOT_W];
      zd_r[0]  <= zq_r[ROOT_W];
    end
  end

  // One quotient bit per stage, three axes side by side
  for (genvar k = 1; k <= Q_W; k++) begin : g_div
    logic [DV_W-1:0] dsh;
    assign dsh = DV_W'(dvs_r[k-1]) << (Q_W - k);
    for (genvar i = 0; i < 3; i++) begin : g_ax
      logic ge;
      assign ge = (num_r[k-1][i] >= dsh);
      always_ff @(posedge clk) begin
        if (en[ST_NUM + k]) begin
          num_r[k][i] <= ge ? (num_r[k-1][i] - dsh) : num_r[k-1][i];
          q_r[k][i]   <= {q_r[k-1][i][Q_W-2:0], ge};
          neg_r[k][i] <= neg_r[k-1][i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en[ST_NUM + k]) begin
        dvs_r[k] <= dvs_r[k-1];
        zd_r[k]  <= zd_r[k-1];
      end
    end
  end

  // Apply sign, saturate, force zero-length vectors to zero
  for (genvar i = 0; i < 3; i++) begin : g_out
    logic [17:0]             qx;
    logic signed [DIR_W-1:0] val_nxt;
    assign qx = 18'(q_r[Q_W][i]);
    always_comb begin
      if (zd_r[Q_W]) begin
        val_nxt = '0;
      end else if (neg_r[Q_W][i]) begin
        val_nxt = (qx > 18'd32768) ? -16'sd32768 : DIR_W'(-$signed(qx));
      end else begin
        val_nxt = (qx > 18'd32767) ? 16'sd32767 : $signed(qx[DIR_W-1:0]);
      end
    end
    always_ff @(posedge clk) begin
      if (en[ST_OUT]) begin
        out_r[i] <= val_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      zero_r <= zd_r[Q_W];
    end
  end

  assign o_x    = out_r[0];
  assign o_y    = out_r[1];
  assign o_z    = out_r[2];
  assign zero_o = zero_r;

endmodule

/* rtl/vertex_transform_normalize.sv */
// Top level: config registers, position lanes, two direction lanes, stage control, merge
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-------------------------------------------
//  in_ch   | sink      | valid/ready      | pos, nrm, tan, tex of one vertex
//  out_ch  | source    | valid/ready      | transformed pos, unit nrm/tan, tex, flags
//  cfg_*   | sink      | cfg_we           | register index, 48-bit write data
//
// One vertex enters per cycle while in_ch.ready is high. The pipeline includes the
// 29-stage square root and the 16-stage divider in each direction lane.
// Every stage holds its own valid bit and advances when it or any later stage has a
// hole or out_ch.ready is high, so bubbles close up while a result waits.
// rst_n (synchronous) clears the stage valid bits and restores the identity matrix.
module vertex_transform_normalize import vtn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  vtn_in_if.sink               in_ch,
  vtn_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0]        row_x_r, row_y_r, row_z_r;
  logic [OFF_W-1:0]        off_x_r, off_y_r, off_z_r;
  logic [NST-1:0]          v_r;
  stage_en_t               en;

  logic signed [P_W-1:0]   pdot [3];
  logic [OFF_W-1:0]        offs [3];
  logic signed [POS_W-1:0] pos_r [ST_SQR:NST-1][3];
  logic [TEX_W-1:0]        tex_r [0:NST-1][2];
  logic                    zn, zt;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r <= ROW_X_RST;
      row_y_r <= ROW_Y_RST;
      row_z_r <= ROW_Z_RST;
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_ROW_X: row_x_r <= cfg_data;
        REG_ROW_Y: row_y_r <= cfg_data;
        REG_ROW_Z: row_z_r <= cfg_data;
        REG_OFF_X: off_x_r <= cfg_data[OFF_W-1:0];
        REG_OFF_Y: off_y_r <= cfg_data[OFF_W-1:0];
        REG_OFF_Z: off_z_r <= cfg_data[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage advance: move when this or a later stage is empty or the result is taken
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = out_ch.ready | ~(&v_r[NST-1:k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ch.ready = en[0];

  // Position lanes: one dot product per output axis
  vtn_dot u_pos_x (.clk(clk), .en_prod(en[ST_PROD]), .en_sum(en[ST_DOT]), .row(row_x_r),
                   .vec_x(in_ch.pos_x), .vec_y(in_ch.pos_y), .vec_z(in_ch.pos_z),
                   .dot_o(pdot[0]));
  vtn_dot u_pos_y (.clk(clk), .en_prod(en[ST_PROD]), .en_sum(en[ST_DOT]), .row(row_y_r),
                   .vec_x(in_ch.pos_x), .vec_y(in_ch.pos_y), .vec_z(in_ch.pos_z),
                   .dot_o(pdot[1]));
  vtn_dot u_pos_z (.clk(clk), .en_prod(en[ST_PROD]), .en_sum(en[ST_DOT]), .row(row_z_r),
                   .vec_x(in_ch.pos_x), .vec_y(in_ch.pos_y), .vec_z(in_ch.pos_z),
                   .dot_o(pdot[2]));

  assign offs[0] = off_x_r;
  assign offs[1] = off_y_r;
  assign offs[2] = off_z_r;

  // Add translation and saturate, then hold alongside the direction lanes
  for (genvar i = 0; i < 3; i++) begin : g_pos
    logic signed [PO_W-1:0]  psum;
    logic signed [POS_W-1:0] psat;
    assign psum = PO_W'(pdot[i]) + PO_W'($signed(offs[i]));
    always_comb begin
      if (psum > POS_MAX) begin
        psat = POS_MAX[POS_W-1:0];
      end else if (psum < POS_MIN) begin
        psat = POS_MIN[POS_W-1:0];
      end else begin
        psat = psum[POS_W-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en[ST_SQR]) begin
        pos_r[ST_SQR][i] <= psat;
      end
    end
    for (genvar k = ST_SQR + 1; k < NST; k++) begin : g_dly
      always_ff @(posedge clk) begin
        if (en[k]) begin
          pos_r[k][i] <= pos_r[k-1][i];
        end
      end
    end
  end

  // Texture coordinates ride along unchanged
  always_ff @(posedge clk) begin
    if (en[0]) begin
      tex_r[0][0] <= in_ch.tex_u;
      tex_r[0][1] <= in_ch.tex_v;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        tex_r[k][0] <= tex_r[k-1][0];
        tex_r[k][1] <= tex_r[k-1][1];
      end
    end
  end

  // Normal and tangent lanes
  vtn_dir_lane u_nrm (.clk(clk), .en(en), .row_x(row_x_r), .row_y(row_y_r), .row_z(row_z_r),
                      .d_x(in_ch.nrm_x), .d_y(in_ch.nrm_y), .d_z(in_ch.nrm_z),
                      .o_x(out_ch.out_nrm_x), .o_y(out_ch.out_nrm_y),
                      .o_z(out_ch.out_nrm_z), .zero_o(zn));
  vtn_dir_lane u_tan (.clk(clk), .en(en), .row_x(row_x_r), .row_y(row_y_r), .row_z(row_z_r),
                      .d_x(in_ch.tan_x), .d_y(in_ch.tan_y), .d_z(in_ch.tan_z),
                      .o_x(out_ch.out_tan_x), .o_y(out_ch.out_tan_y),
                      .o_z(out_ch.out_tan_z), .zero_o(zt));

  // Merge lane results into the output request
  assign out_ch.valid      = v_r[NST-1];
  assign out_ch.out_pos_x  = pos_r[NST-1][0];
  assign out_ch.out_pos_y  = pos_r[NST-1][1];
  assign out_ch.out_pos_z  = pos_r[NST-1][2];
  assign out_ch.out_tex_u  = tex_r[NST-1][0];
  assign out_ch.out_tex_v  = tex_r[NST-1][1];
  assign out_ch.degenerate = {zt, zn};

endmodule
